[design/ordered_array_list_assert.svh]
// Assertion macros shared by the ordered array list RTL.
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define OAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define OAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/oal_pkg.sv]
// Package with types and codes for the ordered array list.
package oal_pkg;

  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_INSERT = 2'd2;
  localparam logic [1:0] MODE_REMOVE = 2'd3;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_BADPOS   = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  localparam int CfgWidth = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_FIND,
    ST_SHUP,
    ST_INSWR,
    ST_SHDN,
    ST_DONE
  } oal_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  fpos;
    logic [31:0] rval;
  } oal_result_t;

endpackage

[design/ordered_array_list.sv]
// Get reads one entry; find scans from entry 0 until a match or the list end; insert and remove
// shift the entries above the position; one request is in work at a time.
// Find, insert and remove step through the entry RAM one entry per cycle over its single
// read port and single write port.
// The input accepts a new item while the previous result waits in the output register.
// Reset (synchronous, rst_n low) empties the list and sets capacity to DEPTH; no RAM sweep.
module ordered_array_list
  import oal_pkg::*;
#(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0: position[8:0], value[40:9], zero fill
  input  logic [47:0] in_tdata,
  // in_tuser fields from bit 0: mode[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata fields from bit 0: found_position[7:0], read_value[39:8], length[48:40], zero fill
  output logic [55:0] out_tdata,
  // out_tuser fields from bit 0: status[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > CfgWidth) ? CNT_W : CfgWidth) + 1;

  oal_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    cap_r, cap_nxt;
  logic [8:0]          pos_r;
  logic [VALUE_WIDTH-1:0] val_r;
  oal_result_t         res_r, res_nxt;
  oal_result_t         out_res_r;
  logic [8:0]          out_len_r;
  logic                out_valid_r;
  logic                load_out;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic             in_accept;
  logic             cfg_wr;
  logic [8:0]       in_position;
  logic [CMP_W-1:0] in_pos_c, pos_c, cnt_c, idx_c;

  assign in_accept   = in_tvalid && in_tready;
  assign in_position = in_tdata[8:0];
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_pos_c    = CMP_W'(in_position);
  assign pos_c       = CMP_W'(pos_r);
  assign cnt_c       = CMP_W'(cnt_r);
  assign idx_c       = CMP_W'(idx_r);

  oal_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    cap_nxt   = cap_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    load_out  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_nxt = '{status: STAT_OK, fpos: 8'd0, rval: 32'd0};
          case (in_tuser)
            MODE_GET: begin
              if (in_pos_c < cnt_c) begin
                mem_raddr = AW'(in_position);
                state_nxt = ST_GET;
              end else begin
                res_nxt.status = STAT_BADPOS;
                state_nxt      = ST_DONE;
              end
            end
            MODE_FIND: begin
              if (cnt_r == '0) begin
                res_nxt.status = STAT_NOTFOUND;
                state_nxt      = ST_DONE;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_FIND;
              end
            end
            MODE_INSERT: begin
              if (cnt_r >= cap_r || cnt_c >= CMP_W'(DEPTH)) begin
                res_nxt.status = STAT_FULL;
                state_nxt      = ST_DONE;
              end else if (in_pos_c > cnt_c) begin
                res_nxt.status = STAT_BADPOS;
                state_nxt      = ST_DONE;
              end else if (in_pos_c == cnt_c) begin
                state_nxt = ST_INSWR;
              end else begin
                // start at the tail: move entry length-1 up first
                mem_raddr = AW'(cnt_r - CNT_W'(1));
                idx_nxt   = cnt_r;
                state_nxt = ST_SHUP;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                res_nxt.status = STAT_EMPTY;
                state_nxt      = ST_DONE;
              end else if (in_pos_c >= cnt_c) begin
                res_nxt.status = STAT_BADPOS;
                state_nxt      = ST_DONE;
              end else if (in_pos_c + CMP_W'(1) == cnt_c) begin
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = ST_DONE;
              end else begin
                mem_raddr = AW'(in_pos_c + CMP_W'(1));
                idx_nxt   = CNT_W'(in_position);
                state_nxt = ST_SHDN;
              end
            end
          endcase
        end
      end
      ST_GET: begin
        res_nxt.rval = 32'(mem_rdata);
        state_nxt    = ST_DONE;
      end
      ST_FIND: begin
        // read data belongs to idx_r; prefetch the next entry meanwhile
        if (mem_rdata == val_r) begin
          res_nxt.fpos = 8'(idx_r);
          state_nxt    = ST_DONE;
        end else if (idx_c + CMP_W'(1) == cnt_c) begin
          res_nxt.status = STAT_NOTFOUND;
          state_nxt      = ST_DONE;
        end else begin
          mem_raddr = AW'(idx_r + CNT_W'(1));
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end
      ST_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        if (idx_c == pos_c + CMP_W'(1)) begin
          state_nxt = ST_INSWR;
        end else begin
          mem_raddr = AW'(idx_r - CNT_W'(2));
          idx_nxt   = idx_r - CNT_W'(1);
        end
      end
      ST_INSWR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = ST_DONE;
      end
      ST_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        if (idx_c + CMP_W'(2) == cnt_c) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_DONE;
        end else begin
          mem_raddr = AW'(idx_r + CNT_W'(2));
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // capacity write: zero is dropped, larger than DEPTH saturates, list empties
    if (cfg_wr && !cfg_paddr[2] && cfg_pwdata[8:0] != 9'd0) begin
      if (CMP_W'(cfg_pwdata[8:0]) > CMP_W'(DEPTH)) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_pwdata[8:0]);
      end
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      cap_r       <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      cap_r   <= cap_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_accept) begin
      pos_r <= in_position;
      val_r <= VALUE_WIDTH'(in_tdata[40:9]);
    end
    if (load_out) begin
      out_res_r <= res_r;
      out_len_r <= 9'(cnt_r);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'd0, out_len_r, out_res_r.rval, out_res_r.fpos};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(cap_r);

`include "ordered_array_list_assert.svh"

  `OAL_ASSERT_SAME(a_cnt_le_cap, 1'b1, cnt_r <= cap_r, "entry count above capacity")
  `OAL_ASSERT_SAME(a_we_in_write_state, mem_we,
    state_r == ST_SHUP || state_r == ST_INSWR || state_r == ST_SHDN,
    "RAM write outside a shift or insert step")
  `OAL_ASSERT_SAME(a_find_in_range, state_r == ST_FIND, idx_c < cnt_c,
    "find index beyond list length")
  `OAL_ASSERT_NEXT(a_remove_empty,
    in_accept && in_tuser == MODE_REMOVE && cnt_r == '0,
    state_r == ST_DONE && res_r.status == STAT_EMPTY,
    "remove on empty list not reported as empty")
  `OAL_ASSERT_NEXT(a_done_holds, state_r == ST_DONE && out_valid_r && !out_tready,
    state_r == ST_DONE && out_valid_r, "result dropped while output stalled")

endmodule

[design/oal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/ordered_array_list_tb.sv]
// Self-checking testbench for the ordered array list: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps

module ordered_array_list_tb;
  import oal_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 300;
  localparam int LIST_DEPTH = 256;
  localparam logic [2:0] CAPACITY_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  position;
    logic [31:0] value;
  } list_op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  fpos;
    logic [31:0] rval;
    logic [8:0]  length;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ordered_array_list u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Shadow of the list and its capacity
  logic [31:0] entries_q[$];
  int unsigned list_capacity = LIST_DEPTH;

  list_op_t    op_q[$];
  list_reply_t reply_q[$];
  list_op_t    cur_op;
  list_reply_t want;

  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  cap_writes = 0;
  int  cycle_count = 0;
  int  gen_len = 0;
  int  in_gap_left = 0;
  int  out_stall_left = 0;
  bit  quiet = 1'b0;
  bit  in_taken = 1'b0;

  logic [31:0] value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                  32'h5555_5555, 32'h0000_0001, 32'h8000_0000};
  logic [31:0] cap_settings [5] = '{32'd2, 32'd7, 32'hFFFF_FE05, 32'd33, 32'h0000_01FF};

  function automatic list_reply_t list_apply(list_op_t op);
    list_reply_t r;
    int count;
    r = '0;
    r.status = STAT_OK;
    count = entries_q.size();
    case (op.mode)
      MODE_GET: begin
        if (op.position < count) r.rval = entries_q[op.position];
        else r.status = STAT_BADPOS;
      end
      MODE_FIND: begin
        r.status = STAT_NOTFOUND;
        for (int j = 0; j < count; j++) begin
          if (entries_q[j] == op.value) begin
            r.status = STAT_OK;
            r.fpos = 8'(j);
            break;
          end
        end
      end
      MODE_INSERT: begin
        // full takes precedence over a bad position
        if (count >= list_capacity) r.status = STAT_FULL;
        else if (op.position > count) r.status = STAT_BADPOS;
        else entries_q.insert(op.position, op.value);
      end
      default: begin
        if (count == 0) r.status = STAT_EMPTY;
        else if (op.position >= count) r.status = STAT_BADPOS;
        else entries_q.delete(op.position);
      end
    endcase
    r.length = 9'(entries_q.size());
    return r;
  endfunction

  function automatic void set_capacity(logic [31:0] data);
    int unsigned v;
    v = data[8:0];
    if (v == 0) return;
    if (v > LIST_DEPTH) v = LIST_DEPTH;
    list_capacity = v;
    entries_q.delete();
  endfunction

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
      errors++;
    end
  endtask

  task automatic add_item(input logic [1:0] mode, input int pos, input logic [31:0] val);
    list_op_t op;
    op.mode = mode;
    op.position = 9'(pos);
    op.value = val;
    op_q.push_back(op);
    items_sent++;
    if (mode == MODE_INSERT && gen_len < list_capacity && pos <= gen_len) gen_len++;
    else if (mode == MODE_REMOVE && pos < gen_len) gen_len--;
  endtask

  task automatic add_random_items(input int n);
    int r;
    int ins_weight;
    int pos;
    logic [1:0] mode;
    logic [31:0] val;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      // grow lists below half capacity, shrink fuller ones
      ins_weight = (2 * gen_len < list_capacity) ? 45 : 25;
      if (r < 25) mode = MODE_GET;
      else if (r < 40) mode = MODE_FIND;
      else if (r < 40 + ins_weight) mode = MODE_INSERT;
      else mode = MODE_REMOVE;
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, LIST_DEPTH);
      else if (mode == MODE_INSERT) pos = $urandom_range(0, gen_len);
      else pos = $urandom_range(0, gen_len > 0 ? gen_len - 1 : 0);
      val = ($urandom_range(0, 2) != 0) ? value_pool[$urandom_range(0, 5)] : $urandom();
      add_item(mode, pos, val);
    end
  endtask

  task automatic drain();
    while (op_q.size() != 0 || in_tvalid || reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    gen_len = entries_q.size();
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == CAPACITY_ADDR) set_capacity(data);
    cap_writes++;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    gen_len = entries_q.size();
  endtask

  task automatic cfg_check_capacity();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= CAPACITY_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("capacity", 32'(list_capacity), cfg_prdata);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Input driver: hold the item until accepted, insert random gaps between items
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (op_q.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
        in_gap_left = $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else if (op_q.size() != 0) begin
        cur_op = op_q.pop_front();
        in_tdata <= {7'b0, cur_op.value, cur_op.position};
        in_tuser <= cur_op.mode;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure in random bursts
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    in_taken = in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      reply_q.push_back(list_apply(list_op_t'{in_tuser, in_tdata[8:0], in_tdata[40:9]}));
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual 0x%0h/0x%0h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = reply_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("found_position", 32'(want.fpos), 32'(out_tdata[7:0]));
        check_field("read_value", want.rval, out_tdata[39:8]);
        check_field("length", 32'(want.length), 32'(out_tdata[48:40]));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still expected",
               $time, cycle_count, reply_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cfg_check_capacity();

    // Empty-list errors, inserts at front and end, duplicates, bad positions
    add_item(MODE_GET, 0, 32'h0);
    add_item(MODE_REMOVE, 0, 32'h0);
    add_item(MODE_FIND, 0, 32'h0);
    add_item(MODE_INSERT, 1, 32'h1);
    add_item(MODE_INSERT, 0, 32'h0000_0000);
    add_item(MODE_INSERT, 1, 32'hFFFF_FFFF);
    add_item(MODE_INSERT, 0, 32'h1234_5678);
    add_item(MODE_INSERT, 4, 32'h0);
    add_item(MODE_INSERT, 3, 32'hFFFF_FFFF);
    add_item(MODE_FIND, 0, 32'hFFFF_FFFF);
    add_item(MODE_FIND, 0, 32'h0000_0000);
    add_item(MODE_FIND, 0, 32'hA5A5_A5A5);
    add_item(MODE_GET, 0, 32'h0);
    add_item(MODE_GET, 3, 32'h0);
    add_item(MODE_GET, 4, 32'h0);
    add_item(MODE_GET, LIST_DEPTH, 32'h0);
    add_item(MODE_REMOVE, 4, 32'h0);
    add_item(MODE_REMOVE, LIST_DEPTH, 32'h0);
    add_item(MODE_REMOVE, 1, 32'h0);
    add_item(MODE_REMOVE, 2, 32'h0);
    add_item(MODE_GET, 1, 32'h0);
    drain();

    // Capacity of one: full before bad position; zero and spare-address writes ignored
    cfg_write(CAPACITY_ADDR, 32'd1);
    cfg_check_capacity();
    add_item(MODE_INSERT, 0, 32'hCAFE_F00D);
    add_item(MODE_INSERT, 0, 32'h1);
    add_item(MODE_INSERT, 5, 32'h1);
    add_item(MODE_FIND, 0, 32'hCAFE_F00D);
    drain();
    cfg_write(CAPACITY_ADDR, 32'd0);
    cfg_check_capacity();
    add_item(MODE_GET, 0, 32'h0);
    drain();
    cfg_write(SPARE_ADDR, 32'd3);
    cfg_check_capacity();
    add_item(MODE_INSERT, 1, 32'h2);
    add_item(MODE_REMOVE, 1, 32'h0);
    add_item(MODE_REMOVE, 0, 32'h0);
    add_item(MODE_REMOVE, 0, 32'h0);
    drain();

    // Oversized capacity saturates; fill the whole store, then probe its ends
    cfg_write(CAPACITY_ADDR, 32'd400);
    cfg_check_capacity();
    for (int i = 0; i < LIST_DEPTH - 1; i++) add_item(MODE_INSERT, gen_len, $urandom());
    add_item(MODE_INSERT, gen_len, 32'hDEAD_BEEF);
    add_item(MODE_FIND, 0, 32'hDEAD_BEEF);
    add_item(MODE_INSERT, 0, 32'h7);
    add_item(MODE_GET, LIST_DEPTH - 1, 32'h0);
    add_item(MODE_GET, LIST_DEPTH, 32'h0);
    add_item(MODE_REMOVE, 0, 32'h0);
    add_item(MODE_INSERT, 0, 32'h7);
    add_item(MODE_REMOVE, LIST_DEPTH - 1, 32'h0);
    drain();

    for (int p = 0; p < 5; p++) begin
      if (p == 4) quiet = 1'b1;
      cfg_write(CAPACITY_ADDR, cap_settings[p]);
      cfg_check_capacity();
      add_random_items(42);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests over %0d register writes, %0d results compared.",
             items_sent, cap_writes, results_checked);
    $display("Capacities 1, 2, 5, 7, 33 and full depth, with stalls on both streams.");
    if (errors == 0 && reply_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, reply_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
